// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the octave smoother.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define FOS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define FOS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fos_pkg.sv =====
// Shared types and constants for the fractional-octave smoother.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package fos_pkg;

	// Field widths.
	localparam int BIN_W      = 12;
	localparam int SAMPLE_W   = 32;
	localparam int SUM_W      = 44;
	localparam int OCT_W      = 16;
	localparam int INV_W      = 17;

	// Fixed-point positions of the two ratios (Q4.12 and Q1.16).
	localparam int OCT_FRAC   = 12;
	localparam int INV_FRAC   = 16;
	localparam int HI_PROD_W  = BIN_W + OCT_W;
	localparam int LO_PROD_W  = BIN_W + INV_W;

	// Step counters of the serial units.
	localparam int MUL_CNT_W  = 4;
	localparam int DIV_CNT_W  = 6;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SMOOTHING_ON  = 2'd0,
		REG_OCTAVE_RATIO  = 2'd1,
		REG_INVERSE_RATIO = 2'd2
	} cfg_reg_t;

	localparam logic [OCT_W-1:0] OCT_RATIO_RESET = 16'd4096;
	localparam logic [INV_W-1:0] INV_RATIO_RESET = 17'd65536;

	// Input mode codes.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// Load request passed from the sequencer to the prefix store.
	typedef struct packed {
		logic                valid;
		logic                restart;
		logic [SAMPLE_W-1:0] sample;
	} load_req_t;

	// Read sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CLAMP,
		ST_RD_HI,
		ST_RD_LO,
		ST_SUB,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/fos_prefix_store.sv =====
// Running prefix-sum accumulator and per-bin prefix memory.
// Depends on fos_pkg for the load request type and field widths.
`default_nettype none

module fos_prefix_store #(
	parameter int MAX_BINS = 4096,
	localparam int AW = $clog2(MAX_BINS),
	localparam int CW = $clog2(MAX_BINS + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire fos_pkg::load_req_t        load_req,
	input  wire logic [AW-1:0]             rd_addr,
	output logic      [fos_pkg::SUM_W-1:0] rd_data,
	output logic      [CW-1:0]             count
);
	import fos_pkg::*;

	logic [SUM_W-1:0] mem [MAX_BINS];
	logic [SUM_W-1:0] sum_q;
	logic [CW-1:0]    count_q;
	logic [SUM_W-1:0] rd_data_q;
	logic [SUM_W-1:0] sum_base;
	logic [SUM_W-1:0] sum_new;
	logic [AW-1:0]    wr_addr;
	logic             wr_en;

	// A restart begins a fresh spectrum; a full store ignores plain loads.
	always_comb begin
		sum_base = load_req.restart ? '0 : sum_q;
		sum_new  = sum_base + SUM_W'(load_req.sample);
		wr_addr  = load_req.restart ? '0 : count_q[AW-1:0];
		wr_en    = load_req.valid && (load_req.restart || (count_q < CW'(MAX_BINS)));
	end

	// Running sum and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (wr_en) begin
			sum_q   <= sum_new;
			count_q <= load_req.restart ? CW'(1) : count_q + CW'(1);
		end
	end

	// Prefix memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= sum_new;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign count   = count_q;

endmodule

`default_nettype wire

// ===== rtl/fos_edge_mul.sv =====
// Bit-serial multiplier that forms both window-edge products of a bin index.
// Depends on fos_pkg for widths and the step counter size.
`default_nettype none

module fos_edge_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [fos_pkg::BIN_W-1:0]     idx,
	input  wire logic [fos_pkg::OCT_W-1:0]     octave_ratio,
	input  wire logic [fos_pkg::INV_W-1:0]     inverse_ratio,
	output logic      [fos_pkg::HI_PROD_W-1:0] hi_prod,
	output logic      [fos_pkg::LO_PROD_W-1:0] lo_prod,
	output logic                               done
);
	import fos_pkg::*;

	logic [BIN_W-1:0]     idx_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [HI_PROD_W-1:0] hi_acc_q;
	logic [LO_PROD_W-1:0] lo_acc_q;

	// Step counter: one index bit per cycle, most significant first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(BIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift-and-add accumulators for both ratios.
	always_ff @(posedge clk) begin
		if (start) begin
			idx_q    <= idx;
			hi_acc_q <= '0;
			lo_acc_q <= '0;
		end else if (busy_q) begin
			idx_q    <= idx_q << 1;
			hi_acc_q <= (hi_acc_q << 1)
				+ (idx_q[BIN_W-1] ? HI_PROD_W'(octave_ratio) : '0);
			lo_acc_q <= (lo_acc_q << 1)
				+ (idx_q[BIN_W-1] ? LO_PROD_W'(inverse_ratio) : '0);
		end
	end

	assign hi_prod = hi_acc_q;
	assign lo_prod = lo_acc_q;
	assign done    = done_q;

endmodule

`default_nettype wire

// ===== rtl/fos_serial_div.sv =====
// Restoring divider producing one quotient bit per cycle for the window mean.
// Depends on fos_pkg for the sum width and the step counter size.
`default_nettype none

module fos_serial_div #(
	parameter int DIV_W = 12
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [fos_pkg::SUM_W-1:0] dividend,
	input  wire logic [DIV_W-1:0]          divisor,
	output logic      [fos_pkg::SUM_W-1:0] quotient,
	output logic                           done
);
	import fos_pkg::*;

	logic [SUM_W-1:0]     quo_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       rem_shift;
	logic [DIV_W:0]       rem_next;
	logic                 take;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		rem_shift = {rem_q, quo_q[SUM_W-1]};
		take      = rem_shift >= {1'b0, dvs_q};
		rem_next  = take ? rem_shift - {1'b0, dvs_q} : rem_shift;
	end

	// Step counter over all dividend bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out as the quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], take};
			rem_q <= rem_next[DIV_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// ===== rtl/fractional_octave_smoother_unit.sv =====
// Top level of the fractional-octave smoother: configuration, read sequencer, output register.
// Depends on fos_pkg, fos_prefix_store, fos_edge_mul, fos_serial_div and assert_macros.svh.
//
// Channel   Handshake              Carries
// in        in_valid / in_stall    mode, restart, power_sample, bin_index
// out       out_valid / out_stall  smoothed_value, index_error
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Loads may arrive on every cycle while no read is in progress.
// A read of a bin not yet loaded goes straight to the result; bin zero or a raw read
// reads the prefix memory. A smoothed read passes through the serial edge multiplier,
// the memory reads and the divider at one quotient bit per cycle.
// No new request is taken while a read is in progress. The output register lets
// a new request in while a result waits; a stalled result holds the next one back.
// Reset clears the fill count, running sum, configuration registers and handshake state only.
`default_nettype none
`include "assert_macros.svh"

module fractional_octave_smoother_unit #(
	parameter int MAX_BINS = 4096
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           mode,
	input  wire logic                           restart,
	input  wire logic [fos_pkg::SAMPLE_W-1:0]   power_sample,
	input  wire logic [fos_pkg::BIN_W-1:0]      bin_index,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [fos_pkg::SAMPLE_W-1:0]   smoothed_value,
	output logic                                index_error,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [fos_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fos_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fos_pkg::*;

	localparam int AW    = $clog2(MAX_BINS);
	localparam int CW    = $clog2(MAX_BINS + 1);
	localparam int SEL_W = (CW > OCT_W) ? CW : OCT_W;

	state_t state_q, state_d;

	// Configuration registers.
	logic             smoothing_on_q;
	logic [OCT_W-1:0] octave_ratio_q;
	logic [INV_W-1:0] inverse_ratio_q;

	// Read context.
	logic [AW-1:0]       hi_q;
	logic [AW-1:0]       lo_q;
	logic                win_q;
	logic                lo_zero_q;
	logic [SUM_W-1:0]    minuend_q;
	logic [SAMPLE_W-1:0] res_val_q;
	logic                res_err_q;

	// Output register.
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_val_q;
	logic                out_err_q;

	// Handshake and control.
	logic in_acc;
	logic out_free;
	logic mul_start;
	logic div_start;
	logic rd_sel_lo;
	logic out_load;
	logic rd_err;
	logic rd_window;

	// Datapath nets.
	load_req_t            load_req;
	logic [AW-1:0]        rd_addr;
	logic [SUM_W-1:0]     rd_data;
	logic [CW-1:0]        load_cnt;
	logic [HI_PROD_W-1:0] mul_hi_prod;
	logic [LO_PROD_W-1:0] mul_lo_prod;
	logic                 mul_done;
	logic [SUM_W-1:0]     div_quo;
	logic                 div_done;
	logic [SUM_W-1:0]     diff;
	logic [AW-1:0]        span;
	logic [SEL_W-1:0]     idx_ext;
	logic [SEL_W-1:0]     hi_full;
	logic [SEL_W-1:0]     lo_full;
	logic [SEL_W-1:0]     last_bin;
	logic [SEL_W-1:0]     hi_min;
	logic [SEL_W-1:0]     lo_min;
	logic [SEL_W-1:0]     hi_adj;
	logic [SEL_W-1:0]     lo_adj;

	// Configuration writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothing_on_q  <= 1'b0;
			octave_ratio_q  <= OCT_RATIO_RESET;
			inverse_ratio_q <= INV_RATIO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SMOOTHING_ON:  smoothing_on_q  <= cfg_data[0];
				REG_OCTAVE_RATIO:  octave_ratio_q  <= cfg_data[OCT_W-1:0];
				REG_INVERSE_RATIO: inverse_ratio_q <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	// Classification of an incoming read.
	always_comb begin
		idx_ext   = SEL_W'(bin_index);
		rd_err    = idx_ext >= SEL_W'(load_cnt);
		rd_window = smoothing_on_q && (bin_index != '0);
	end

	// Window edges: clamp to the last loaded bin and keep the window non-empty.
	always_comb begin
		hi_full  = SEL_W'(mul_hi_prod[HI_PROD_W-1:OCT_FRAC]);
		lo_full  = SEL_W'(mul_lo_prod[LO_PROD_W-1:INV_FRAC]);
		last_bin = SEL_W'(load_cnt) - SEL_W'(1);
		hi_min   = (hi_full > last_bin) ? last_bin : hi_full;
		lo_min   = (lo_full > hi_min) ? hi_min : lo_full;
		hi_adj   = hi_min;
		lo_adj   = lo_min;
		priority if (lo_min == hi_min && hi_min != '0) begin
			lo_adj = hi_min - SEL_W'(1);
		end else if (lo_min == hi_min) begin
			lo_adj = '0;
			hi_adj = SEL_W'(1);
		end
	end

	// Difference of the two prefix sums, modulo the sum width.
	assign diff = minuend_q - (lo_zero_q ? '0 : rd_data);
	assign span = hi_q - lo_q;

	// Next-state logic of the read sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && mode == MODE_READ) begin
					priority if (rd_err) state_d = ST_DONE;
					else if (rd_window) state_d = ST_MUL;
					else state_d = ST_RD_HI;
				end
			end
			ST_MUL: begin
				if (mul_done) state_d = ST_CLAMP;
			end
			ST_CLAMP: state_d = ST_RD_HI;
			ST_RD_HI: state_d = ST_RD_LO;
			ST_RD_LO: state_d = ST_SUB;
			ST_SUB: state_d = win_q ? ST_DIV : ST_DONE;
			ST_DIV: begin
				if (div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
		endcase
	end

	// Control outputs of the read sequencer.
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		in_acc    = in_valid && !in_stall;
		out_free  = !out_valid_q || !out_stall;
		mul_start = in_acc && mode == MODE_READ && !rd_err && rd_window;
		div_start = (state_q == ST_SUB) && win_q;
		rd_sel_lo = (state_q == ST_RD_LO);
		out_load  = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Read context and result capture.
	always_ff @(posedge clk) begin
		if (in_acc && mode == MODE_READ) begin
			hi_q      <= idx_ext[AW-1:0];
			lo_q      <= idx_ext[AW-1:0] - AW'(1);
			lo_zero_q <= (bin_index == '0);
			win_q     <= 1'b0;
			res_val_q <= '0;
			res_err_q <= rd_err;
		end
		if (state_q == ST_CLAMP) begin
			hi_q      <= hi_adj[AW-1:0];
			lo_q      <= lo_adj[AW-1:0];
			lo_zero_q <= 1'b0;
			win_q     <= 1'b1;
		end
		if (state_q == ST_RD_LO) begin
			minuend_q <= rd_data;
		end
		if (state_q == ST_SUB && !win_q) begin
			res_val_q <= diff[SAMPLE_W-1:0];
		end
		if (state_q == ST_DIV && div_done) begin
			res_val_q <= (div_quo[SUM_W-1:SAMPLE_W] != '0) ? '1 : div_quo[SAMPLE_W-1:0];
		end
	end

	// Output register: a waiting result does not block the input side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_val_q <= res_val_q;
			out_err_q <= res_err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign smoothed_value = out_val_q;
	assign index_error    = out_err_q;

	// Load requests go straight to the prefix store.
	always_comb begin
		load_req.valid   = in_acc && mode == MODE_LOAD;
		load_req.restart = restart;
		load_req.sample  = power_sample;
	end

	assign rd_addr = rd_sel_lo ? lo_q : hi_q;

	fos_prefix_store #(
		.MAX_BINS (MAX_BINS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_req (load_req),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.count    (load_cnt)
	);

	fos_edge_mul u_mul (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (mul_start),
		.idx           (bin_index),
		.octave_ratio  (octave_ratio_q),
		.inverse_ratio (inverse_ratio_q),
		.hi_prod       (mul_hi_prod),
		.lo_prod       (mul_lo_prod),
		.done          (mul_done)
	);

	fos_serial_div #(
		.DIV_W (AW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff),
		.divisor  (span),
		.quotient (div_quo),
		.done     (div_done)
	);

	// The serial units only finish while the sequencer waits for them.
	`FOS_ASSERT_IMPL(a_mul_done_state, mul_done, state_q == ST_MUL, "multiplier finished outside its wait state")
	`FOS_ASSERT_IMPL(a_div_done_state, div_done, state_q == ST_DIV, "divider finished outside its wait state")
	// A read beyond the loaded bins goes straight to the result with the error flag.
	`FOS_ASSERT_NEXT(a_err_path, in_acc && mode == MODE_READ && rd_err, state_q == ST_DONE && res_err_q, "unloaded bin read did not flag an error")
	// A plain load into a store with room advances the fill count by one.
	`FOS_ASSERT_NEXT(a_load_count, load_req.valid && !restart && load_cnt < CW'(MAX_BINS), load_cnt == CW'($past(load_cnt) + 1'b1), "fill count did not advance on a load")

endmodule

`default_nettype wire
